### rtl/pidstep_pkg.sv
// ----------------------------------------------------------------------------
// pidstep_pkg
// Widths, register map and reset values for the PID position to step rate unit.
// ----------------------------------------------------------------------------
package pidstep_pkg;

  // fixed point fraction of the gains
  localparam int FRAC_BITS = 16;

  // field widths
  localparam int POS_W   = 32;
  localparam int ERR_W   = POS_W + 1;      // target - measured
  localparam int DIFF_W  = ERR_W + 1;      // error - last error
  localparam int SUM_W   = 32;             // clamped error sum
  localparam int GAIN_W  = 32;
  localparam int FREQ_W  = 20;
  localparam int DB_W    = 16;
  localparam int BOUND_W = 31;

  // product and total widths
  localparam int PROP_W  = GAIN_W + ERR_W;
  localparam int INTEG_W = GAIN_W + SUM_W;
  localparam int DERIV_W = GAIN_W + DIFF_W;
  localparam int TOTAL_W = DERIV_W + 2;
  localparam int MAG_W   = TOTAL_W - FRAC_BITS;

  // configuration port
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int IDX_W   = 3;

  // register indexes
  localparam logic [IDX_W-1:0] REG_GAIN_PROP     = 3'd0;
  localparam logic [IDX_W-1:0] REG_GAIN_INTEG_DT = 3'd1;
  localparam logic [IDX_W-1:0] REG_GAIN_DERIV_DT = 3'd2;
  localparam logic [IDX_W-1:0] REG_FREQ_CEILING  = 3'd3;
  localparam logic [IDX_W-1:0] REG_DEADBAND      = 3'd4;
  localparam logic [IDX_W-1:0] REG_INTEG_BOUND   = 3'd5;
  localparam logic [IDX_W-1:0] REG_REVERSE_DIR   = 3'd6;

  // reset values
  localparam logic [FREQ_W-1:0]  FREQ_CEILING_RST = 20'd1000;
  localparam logic [DB_W-1:0]    DEADBAND_RST     = 16'd2;
  localparam logic [BOUND_W-1:0] INTEG_BOUND_RST  = 31'd400000;

endpackage

### rtl/pid_position_to_step_rate_unit.sv
// ----------------------------------------------------------------------------
// pid_position_to_step_rate_unit
// PID position controller with deadband and integral clamp, giving a step
// frequency magnitude and a direction bit for each calibrated control tick.
// ----------------------------------------------------------------------------
// an input transfer reaches the output through the stage 1, 2, 3 and output registers
// throughput: one item per cycle without stalls; the error sum and last error
//   update in the input stage, and the three gain multipliers sit in their own stage
// ticks with the calibrated flag clear give no result and change no state
// reset (synchronous, active high) clears the pipeline, error sum, last error
//   and sets every register to its documented reset value
module pid_position_to_step_rate_unit
  import pidstep_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // input stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [63:0]       s_axis_tdata,   // target_position[31:0], measured_position[63:32]
  input  logic              s_axis_tuser,   // calibrated
  // result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [23:0]       m_axis_tdata,   // freq_hz[19:0], zero[23:20]
  output logic [1:0]        m_axis_tuser,   // direction[0], in_deadband[1]
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  // configuration registers
  logic signed [GAIN_W-1:0] gain_prop;
  logic signed [GAIN_W-1:0] gain_integ_dt;
  logic signed [GAIN_W-1:0] gain_deriv_per_dt;
  logic [FREQ_W-1:0]        freq_ceiling;
  logic [DB_W-1:0]          deadband_steps;
  logic [BOUND_W-1:0]       integ_bound;
  logic                     reverse_dir;

  logic [IDX_W-1:0] reg_idx;
  logic             cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_prop         <= '0;
      gain_integ_dt     <= '0;
      gain_deriv_per_dt <= '0;
      freq_ceiling      <= FREQ_CEILING_RST;
      deadband_steps    <= DEADBAND_RST;
      integ_bound       <= INTEG_BOUND_RST;
      reverse_dir       <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_GAIN_PROP:     gain_prop         <= pwdata[GAIN_W-1:0];
        REG_GAIN_INTEG_DT: gain_integ_dt     <= pwdata[GAIN_W-1:0];
        REG_GAIN_DERIV_DT: gain_deriv_per_dt <= pwdata[GAIN_W-1:0];
        REG_FREQ_CEILING:  freq_ceiling      <= pwdata[FREQ_W-1:0];
        REG_DEADBAND:      deadband_steps    <= pwdata[DB_W-1:0];
        REG_INTEG_BOUND:   integ_bound       <= pwdata[BOUND_W-1:0];
        REG_REVERSE_DIR:   reverse_dir       <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (reg_idx)
      REG_GAIN_PROP:     prdata = gain_prop;
      REG_GAIN_INTEG_DT: prdata = gain_integ_dt;
      REG_GAIN_DERIV_DT: prdata = gain_deriv_per_dt;
      REG_FREQ_CEILING:  prdata = {{(DATA_W-FREQ_W){1'b0}}, freq_ceiling};
      REG_DEADBAND:      prdata = {{(DATA_W-DB_W){1'b0}}, deadband_steps};
      REG_INTEG_BOUND:   prdata = {{(DATA_W-BOUND_W){1'b0}}, integ_bound};
      REG_REVERSE_DIR:   prdata = {{(DATA_W-1){1'b0}}, reverse_dir};
      default:           prdata = '0;
    endcase
  end

  // pipeline handshake: each stage loads when empty or when it drains
  logic v1, v2, v3, out_valid;
  logic rdy1, rdy2, rdy3, rdy_out;
  logic in_xfer;

  assign rdy_out       = !out_valid || m_axis_tready;
  assign rdy3          = !v3 || rdy_out;
  assign rdy2          = !v2 || rdy3;
  assign rdy1          = !v1 || rdy2;
  assign s_axis_tready = rdy1;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // input stage: error, deadband test, clamped error sum, derivative term
  logic [POS_W-1:0]         tgt, meas;
  logic signed [ERR_W-1:0]  err;
  logic [ERR_W-1:0]         mag_err;
  logic                     db_now;
  logic signed [SUM_W-1:0]  error_sum;
  logic signed [DIFF_W-1:0] last_error;
  logic signed [DIFF_W-1:0] err_x;
  logic signed [DIFF_W-1:0] sum_raw;
  logic signed [DIFF_W-1:0] bound_pos, bound_neg;
  logic signed [SUM_W-1:0]  sum_clamp;
  logic signed [DIFF_W-1:0] diff;

  assign tgt  = s_axis_tdata[POS_W-1:0];
  assign meas = s_axis_tdata[2*POS_W-1:POS_W];

  always_comb begin
    err       = $signed({tgt[POS_W-1], tgt}) - $signed({meas[POS_W-1], meas});
    mag_err   = err[ERR_W-1] ? ERR_W'(-err) : err;
    db_now    = mag_err < {{(ERR_W-DB_W){1'b0}}, deadband_steps};
    err_x     = {err[ERR_W-1], err};
    sum_raw   = $signed({{(DIFF_W-SUM_W){error_sum[SUM_W-1]}}, error_sum}) + err_x;
    bound_pos = $signed({{(DIFF_W-BOUND_W){1'b0}}, integ_bound});
    bound_neg = -bound_pos;
    if (sum_raw > bound_pos) begin
      sum_clamp = bound_pos[SUM_W-1:0];
    end else if (sum_raw < bound_neg) begin
      sum_clamp = bound_neg[SUM_W-1:0];
    end else begin
      sum_clamp = sum_raw[SUM_W-1:0];
    end
    diff = err_x - last_error;
  end

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum  <= '0;
      last_error <= '0;
    end else if (in_xfer && s_axis_tuser) begin
      if (db_now) begin
        error_sum <= '0;
      end else begin
        error_sum  <= sum_clamp;
        last_error <= err_x;
      end
    end
  end

  // stage 1 registers
  logic signed [ERR_W-1:0]  s1_err;
  logic signed [SUM_W-1:0]  s1_sum;
  logic signed [DIFF_W-1:0] s1_diff;
  logic                     s1_db;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_xfer && s_axis_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_err  <= err;
      s1_sum  <= sum_clamp;
      s1_diff <= diff;
      s1_db   <= db_now;
    end
  end

  // stage 2: gain products
  logic signed [PROP_W-1:0]  s2_prop;
  logic signed [INTEG_W-1:0] s2_integ;
  logic signed [DERIV_W-1:0] s2_deriv;
  logic                      s2_db;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_prop  <= gain_prop * s1_err;
      s2_integ <= gain_integ_dt * s1_sum;
      s2_deriv <= gain_deriv_per_dt * s1_diff;
      s2_db    <= s1_db;
    end
  end

  // stage 3: exact sum of the three terms
  logic signed [TOTAL_W-1:0] s3_total;
  logic                      s3_db;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_total <= $signed({{(TOTAL_W-PROP_W){s2_prop[PROP_W-1]}}, s2_prop})
                + $signed({{(TOTAL_W-INTEG_W){s2_integ[INTEG_W-1]}}, s2_integ})
                + $signed({{(TOTAL_W-DERIV_W){s2_deriv[DERIV_W-1]}}, s2_deriv});
      s3_db    <= s2_db;
    end
  end

  // output stage: magnitude truncated to whole hertz, then saturated
  logic [TOTAL_W-1:0] total_mag;
  logic [MAG_W-1:0]   hz;
  logic [FREQ_W-1:0]  freq_sat;
  logic               neg;

  always_comb begin
    neg       = s3_total[TOTAL_W-1];
    total_mag = neg ? TOTAL_W'(-s3_total) : s3_total;
    hz        = total_mag[TOTAL_W-1:FRAC_BITS];
    if ((|hz[MAG_W-1:FREQ_W]) || (hz[FREQ_W-1:0] > freq_ceiling)) begin
      freq_sat = freq_ceiling;
    end else begin
      freq_sat = hz[FREQ_W-1:0];
    end
  end

  logic [FREQ_W-1:0] out_freq;
  logic              out_dir;
  logic              out_db;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy_out) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out) begin
      out_freq <= s3_db ? '0 : freq_sat;
      out_dir  <= s3_db ? 1'b0 : (neg ^ reverse_dir);
      out_db   <= s3_db;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(24-FREQ_W){1'b0}}, out_freq};
  assign m_axis_tuser  = {out_db, out_dir};

  // checks
  a_deadband_result: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == '0 && !m_axis_tuser[0])
    else $error("deadband result carries a nonzero frequency or direction");

  a_freq_ceiling: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[FREQ_W-1:0] <= freq_ceiling)
    else $error("result frequency above the ceiling");

  a_deadband_clears_sum: assert property (@(posedge clk) disable iff (rst)
    in_xfer && s_axis_tuser && db_now |=> error_sum == '0)
    else $error("error sum not cleared inside the deadband");

  a_uncal_no_item: assert property (@(posedge clk) disable iff (rst)
    in_xfer && !s_axis_tuser |=> !v1)
    else $error("uncalibrated tick entered the pipeline");

endmodule
